// ----- sv/spq_pkg.sv -----
package spq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int COUNT_W         = 5;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_CHANGE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_EMPTY     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_FULL      = 2'd3;

    localparam logic [1:0] CELL_HOLD   = 2'd0;
    localparam logic [1:0] CELL_INSERT = 2'd1;
    localparam logic [1:0] CELL_DROP   = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] entry_id;
        logic [15:0] entry_priority;
    } spq_in_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [15:0]        removed_id;
        logic [15:0]        front_id;
        logic [15:0]        front_priority;
        logic               is_empty;
        logic [COUNT_W-1:0] entry_count;
    } spq_out_t;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] key_id;
        logic [15:0] key_prio;
        logic        lt_front;
        logic        match_en;
    } spq_cmd_t;

endpackage

// ----- sv/spq_cell.sv -----
module spq_cell import spq_pkg::*; #(
    parameter int IDX   = 0,
    parameter int OCC_W = 5
) (
    input  logic             aclk,
    input  spq_cmd_t         cmd,
    input  logic [OCC_W-1:0] occ,
    input  logic [15:0]      prev_id,
    input  logic [15:0]      prev_prio,
    input  logic             prev_ins,
    input  logic [15:0]      next_id,
    input  logic [15:0]      next_prio,
    input  logic             hit_in,
    output logic [15:0]      id,
    output logic [15:0]      prio,
    output logic             ins_after,
    output logic             hit_out
);

    localparam bit IS_HEAD = (IDX == 0);

    logic [15:0] id_reg, id_next;
    logic [15:0] prio_reg, prio_next;
    logic        held;

    assign held    = occ > OCC_W'(IDX);
    assign hit_out = hit_in || (cmd.match_en && held && id_reg == cmd.key_id);
    assign ins_after = IS_HEAD ? cmd.lt_front
                               : (cmd.lt_front || !held || prio_reg >= cmd.key_prio);

    always_comb begin
        id_next   = id_reg;
        prio_next = prio_reg;
        unique case (cmd.op)
            CELL_INSERT: begin
                if (ins_after) begin
                    id_next   = prev_ins ? prev_id   : cmd.key_id;
                    prio_next = prev_ins ? prev_prio : cmd.key_prio;
                end
            end
            CELL_DROP: begin
                if (hit_out) begin
                    id_next   = next_id;
                    prio_next = next_prio;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        prio_reg <= prio_next;
    end

    assign id   = id_reg;
    assign prio = prio_reg;

endmodule

// ----- sv/sorted_priority_queue.sv -----
// Sorted priority queue of (id, priority) entries, lowest priority at the front.
// s_ channel: one operation per beat (insert, remove front, change priority,
// clear). m_ channel: one result beat per operation, in order, giving status,
// removed id, front entry, empty flag and count after the operation.
// Entries sit in a row of cells; all cells compare against the key and shift
// towards or away from the front in the same cycle.
// Insert, remove and clear commit at the accepting edge; their result is then
// registered in the output register, or in the skid register while the
// receiver stalls. A priority change drops the entry, then reinserts it in the
// ST_REINS state. A new operation waits until the last result is registered.
// Reset empties the queue and drops any pending result; no clearing pass.
// When the receiver stalls, one result waits in the output register and a
// second in a skid register; s_ready then stays low until the skid drains.
module sorted_priority_queue import spq_pkg::*; #(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  spq_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output spq_out_t m_data
);

    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic ST_IDLE  = 1'b0;
    localparam logic ST_REINS = 1'b1;

    logic state_reg, state_next;
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic [15:0] key_id_reg, key_prio_reg;
    logic rep_valid_reg, rep_valid_next;
    logic [1:0] rep_status_reg, rep_status_next;
    logic [15:0] rep_removed_reg, rep_removed_next;
    logic m_valid_reg, skid_valid_reg;
    spq_out_t m_data_reg, skid_reg, result;

    logic accept, found, m_pop;
    logic [15:0] key_id, key_prio;
    logic [31:0] occ_wide;
    spq_cmd_t cmd;

    logic [15:0] cell_id [QUEUE_DEPTH];
    logic [15:0] cell_prio [QUEUE_DEPTH];
    logic        cell_ins [QUEUE_DEPTH];
    logic        cell_hit [QUEUE_DEPTH];
    logic        hit_head;

    assign s_ready = (state_reg == ST_IDLE) && !rep_valid_reg && !skid_valid_reg;
    assign accept  = s_valid && s_ready;
    assign found   = cell_hit[QUEUE_DEPTH-1];

    assign key_id   = (state_reg == ST_REINS) ? key_id_reg   : s_data.entry_id;
    assign key_prio = (state_reg == ST_REINS) ? key_prio_reg : s_data.entry_priority;

    // cell row command
    always_comb begin
        cmd.op       = CELL_HOLD;
        cmd.key_id   = key_id;
        cmd.key_prio = key_prio;
        cmd.lt_front = (occ_reg == '0) || (key_prio < cell_prio[0]);
        cmd.match_en = 1'b0;
        hit_head     = 1'b0;
        if (state_reg == ST_REINS) begin
            cmd.op = CELL_INSERT;
        end else if (accept) begin
            unique case (s_data.opcode)
                OP_INSERT: begin
                    if (occ_reg != OCC_W'(QUEUE_DEPTH)) begin
                        cmd.op = CELL_INSERT;
                    end
                end
                OP_REMOVE: begin
                    if (occ_reg != '0) begin
                        cmd.op   = CELL_DROP;
                        hit_head = 1'b1;
                    end
                end
                OP_CHANGE: begin
                    cmd.op       = CELL_DROP;
                    cmd.match_en = 1'b1;
                end
                OP_CLEAR: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next       = state_reg;
        occ_next         = occ_reg;
        rep_valid_next   = 1'b0;
        rep_status_next  = rep_status_reg;
        rep_removed_next = rep_removed_reg;
        if (state_reg == ST_REINS) begin
            occ_next        = occ_reg + 1'b1;
            state_next      = ST_IDLE;
            rep_valid_next  = 1'b1;
            rep_status_next = ST_OK;
            rep_removed_next = '0;
        end else if (accept) begin
            rep_status_next  = ST_OK;
            rep_removed_next = '0;
            rep_valid_next   = 1'b1;
            unique case (s_data.opcode)
                OP_INSERT: begin
                    if (occ_reg == OCC_W'(QUEUE_DEPTH)) begin
                        rep_status_next = ST_FULL;
                    end else begin
                        occ_next = occ_reg + 1'b1;
                    end
                end
                OP_REMOVE: begin
                    if (occ_reg == '0) begin
                        rep_status_next = ST_EMPTY;
                    end else begin
                        rep_removed_next = cell_id[0];
                        occ_next         = occ_reg - 1'b1;
                    end
                end
                OP_CHANGE: begin
                    if (found) begin
                        occ_next       = occ_reg - 1'b1;
                        state_next     = ST_REINS;
                        rep_valid_next = 1'b0;
                    end else begin
                        rep_status_next = ST_NOT_FOUND;
                    end
                end
                OP_CLEAR: begin
                    occ_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        spq_cell #(
            .IDX   (i),
            .OCC_W (OCC_W)
        ) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .occ       (occ_reg),
            .prev_id   ((i == 0) ? key_id   : cell_id[(i == 0) ? 0 : i-1]),
            .prev_prio ((i == 0) ? key_prio : cell_prio[(i == 0) ? 0 : i-1]),
            .prev_ins  ((i == 0) ? 1'b0     : cell_ins[(i == 0) ? 0 : i-1]),
            .next_id   (cell_id[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .next_prio (cell_prio[(i == QUEUE_DEPTH-1) ? i : i+1]),
            .hit_in    ((i == 0) ? hit_head : cell_hit[(i == 0) ? 0 : i-1]),
            .id        (cell_id[i]),
            .prio      (cell_prio[i]),
            .ins_after (cell_ins[i]),
            .hit_out   (cell_hit[i])
        );
    end

    assign occ_wide = 32'(occ_reg);

    always_comb begin
        result.status         = rep_status_reg;
        result.removed_id     = rep_removed_reg;
        result.front_id       = (occ_reg != '0) ? cell_id[0]   : '0;
        result.front_priority = (occ_reg != '0) ? cell_prio[0] : '0;
        result.is_empty       = (occ_reg == '0);
        result.entry_count    = occ_wide[COUNT_W-1:0];
    end

    assign m_pop = m_valid_reg && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            occ_reg        <= '0;
            rep_valid_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            occ_reg       <= occ_next;
            rep_valid_reg <= rep_valid_next;
            // a new result only arrives while the skid is empty
            if (rep_valid_reg) begin
                if (!m_valid_reg || m_pop) begin
                    m_data_reg  <= result;
                    m_valid_reg <= 1'b1;
                end else begin
                    skid_reg       <= result;
                    skid_valid_reg <= 1'b1;
                end
            end else if (m_pop) begin
                if (skid_valid_reg) begin
                    m_data_reg     <= skid_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rep_status_reg  <= rep_status_next;
        rep_removed_reg <= rep_removed_next;
        if (accept) begin
            key_id_reg   <= s_data.entry_id;
            key_prio_reg <= s_data.entry_priority;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_occ_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= OCC_W'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");

    a_reins_follows_change: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.opcode == OP_CHANGE && found |=> state_reg == ST_REINS)
        else $error("change without reinsert");

    a_report_skid_free: assert property (@(posedge aclk) disable iff (!aresetn)
        rep_valid_reg |-> !skid_valid_reg)
        else $error("result with no room");

    a_insert_count: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_data.opcode == OP_INSERT && occ_reg != OCC_W'(QUEUE_DEPTH)
        |=> occ_reg == $past(occ_reg) + 1'b1)
        else $error("insert count mismatch");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import spq_pkg::*;

    class prio_queue_scoreboard;
        logic [15:0] q_id   [QUEUE_DEPTH_DEF];
        logic [15:0] q_prio [QUEUE_DEPTH_DEF];
        int          fill;
        spq_out_t    expected_results[$];
        int          errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        function void place(logic [15:0] id, logic [15:0] pr);
            int pos;
            pos = fill;
            if (fill == 0 || pr < q_prio[0]) begin
                pos = 0;
            end else begin
                for (int i = fill - 1; i >= 1; i--) begin
                    if (q_prio[i] >= pr) pos = i;
                end
            end
            for (int i = fill; i > pos; i--) begin
                q_id[i]   = q_id[i-1];
                q_prio[i] = q_prio[i-1];
            end
            q_id[pos]   = id;
            q_prio[pos] = pr;
            fill++;
        endfunction

        function void take_out(int pos);
            for (int i = pos; i < fill - 1; i++) begin
                q_id[i]   = q_id[i+1];
                q_prio[i] = q_prio[i+1];
            end
            fill--;
        endfunction

        function logic [15:0] held_id();
            if (fill == 0) return 16'($urandom_range(15));
            return q_id[$urandom_range(fill - 1)];
        endfunction

        function void record_op(spq_in_t op);
            spq_out_t r;
            int       hit;
            r        = '0;
            r.status = ST_OK;
            case (op.opcode)
                OP_INSERT: begin
                    if (fill >= QUEUE_DEPTH_DEF) r.status = ST_FULL;
                    else place(op.entry_id, op.entry_priority);
                end
                OP_REMOVE: begin
                    if (fill == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.removed_id = q_id[0];
                        take_out(0);
                    end
                end
                OP_CHANGE: begin
                    hit = -1;
                    for (int i = fill - 1; i >= 0; i--) begin
                        if (q_id[i] == op.entry_id) hit = i;
                    end
                    if (hit < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        take_out(hit);
                        place(op.entry_id, op.entry_priority);
                    end
                end
                default: fill = 0;
            endcase
            if (fill != 0) begin
                r.front_id       = q_id[0];
                r.front_priority = q_prio[0];
            end
            r.is_empty    = (fill == 0);
            r.entry_count = COUNT_W'(fill);
            expected_results.push_back(r);
        endfunction

        function void check_result(spq_out_t got);
            spq_out_t want;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result beat: %p", got);
                return;
            end
            want = expected_results.pop_front();
            if (got.status !== want.status || got.removed_id !== want.removed_id ||
                    got.front_id !== want.front_id ||
                    got.front_priority !== want.front_priority ||
                    got.is_empty !== want.is_empty ||
                    got.entry_count !== want.entry_count) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp st=%0d rm=%h fid=%h fpr=%h emp=%0d cnt=%0d",
                             want.status, want.removed_id, want.front_id,
                             want.front_priority, want.is_empty, want.entry_count);
                    $display("         got st=%0d rm=%h fid=%h fpr=%h emp=%0d cnt=%0d",
                             got.status, got.removed_id, got.front_id,
                             got.front_priority, got.is_empty, got.entry_count);
                end
            end
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic     aclk = 1'b0;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    spq_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    spq_out_t m_data;

    prio_queue_scoreboard sb = new();

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    bit hold_req     = 1'b0;
    int hold_left    = 0;

    always #6 aclk = ~aclk;

    sorted_priority_queue i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.record_op(s_data);
            if (m_valid === 1'b1 && m_ready) sb.check_result(m_data);
        end
    end

    // receiver: random stalls plus one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_idle_pct);
            end
        end
    end

    initial begin
        #5ms;
        $display("TB_ERROR");
        $finish;
    end

    function automatic spq_in_t mk_op(logic [1:0] op, logic [15:0] id, logic [15:0] pr);
        spq_in_t t;
        t.opcode         = op;
        t.entry_id       = id;
        t.entry_priority = pr;
        return t;
    endfunction

    // kind: 0 filling, 1 draining, 2 mixed
    function automatic spq_in_t gen_op(int kind);
        int          r;
        int          p;
        logic [1:0]  op;
        logic [15:0] id;
        logic [15:0] pr;
        r = $urandom_range(99);
        case (kind)
            0:       op = (r < 80) ? OP_INSERT : (r < 88) ? OP_REMOVE :
                          (r < 98) ? OP_CHANGE : OP_CLEAR;
            1:       op = (r < 15) ? OP_INSERT : (r < 80) ? OP_REMOVE :
                          (r < 97) ? OP_CHANGE : OP_CLEAR;
            default: op = (r < 40) ? OP_INSERT : (r < 70) ? OP_REMOVE :
                          (r < 97) ? OP_CHANGE : OP_CLEAR;
        endcase
        if (op == OP_CHANGE && $urandom_range(99) < 75) id = sb.held_id();
        else if ($urandom_range(99) < 60) id = 16'($urandom_range(15));
        else id = 16'($urandom_range(65535));
        p = $urandom_range(99);
        if (p < 50)      pr = 16'($urandom_range(31));
        else if (p < 90) pr = 16'($urandom_range(65535));
        else             pr = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return mk_op(op, id, pr);
    endfunction

    task automatic send_op(spq_in_t op);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= op;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_random(int n_items);
        int kind;
        kind = 0;
        for (int i = 0; i < n_items; i++) begin
            if (i % 40 == 0 && i != 0) kind = $urandom_range(2);
            send_op(gen_op(kind));
        end
    endtask

    spq_in_t directed[$];

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        directed = '{
            mk_op(OP_REMOVE, 16'd0,     16'd0),
            mk_op(OP_CHANGE, 16'd5,     16'd9),
            mk_op(OP_CLEAR,  16'd0,     16'd0),
            mk_op(OP_INSERT, 16'd5,     16'd100),
            mk_op(OP_INSERT, 16'd6,     16'd100),
            mk_op(OP_INSERT, 16'd7,     16'd50),
            mk_op(OP_INSERT, 16'd7,     16'd200),
            mk_op(OP_CHANGE, 16'd7,     16'd300),
            mk_op(OP_CHANGE, 16'd6,     16'd0),
            mk_op(OP_CHANGE, 16'd6,     16'hFFFF),
            mk_op(OP_CHANGE, 16'd1234,  16'd1),
            mk_op(OP_INSERT, 16'h0000,  16'h0000),
            mk_op(OP_INSERT, 16'hFFFF,  16'hFFFF),
            mk_op(OP_INSERT, 16'hAAAA,  16'h5555),
            mk_op(OP_INSERT, 16'h5555,  16'hAAAA),
            mk_op(OP_CHANGE, 16'h0000,  16'h0000),
            mk_op(OP_REMOVE, 16'hFFFF,  16'hFFFF),
            mk_op(OP_REMOVE, 16'd0,     16'd0),
            mk_op(OP_CLEAR,  16'hFFFF,  16'hFFFF),
            mk_op(OP_REMOVE, 16'd0,     16'd0)
        };
        foreach (directed[i]) send_op(directed[i]);

        src_idle_pct = 35;
        snk_idle_pct = 45;
        run_random(270);

        src_idle_pct = 45;
        snk_idle_pct = 35;
        run_random(270);

        src_idle_pct = 0;
        snk_idle_pct = 0;
        hold_req     = 1'b1;
        run_random(270);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- files.f -----
sv/spq_pkg.sv
sv/spq_cell.sv
sv/sorted_priority_queue.sv
dv/tb_top.sv
